### rtl/vftm_pkg.sv
// shared types and constants for the vsync flip timing monitor
// no dependencies; every other file of the block but vftm_ram imports this package

package vftm_pkg;

  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int CNT_W   = 32;
  localparam int NOW_W   = 63;
  localparam int STAMP_W = 64;
  localparam int OUT_W   = 32;

  localparam int PENDING_DEPTH_DEF = 16;

  localparam logic [STAMP_W-1:0] NS_PER_SEC = 64'd1_000_000_000;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE  = 1'b1;
  localparam logic [OUT_W-1:0]     EXPECTED_RST = 32'd16_666_666;

  typedef enum logic [1:0] {
    KIND_FLIP    = 2'd0,
    KIND_SUBMIT  = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_RESET   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEC_W-1:0]  flip_seconds;
    logic [USEC_W-1:0] flip_micros;
    logic [CNT_W-1:0]  flip_counter;
    logic [NOW_W-1:0]  now_ns;
  } vftm_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] period_ns;
    logic [OUT_W-1:0] skipped_count;
    logic [OUT_W-1:0] drop_total;
    logic             latency_valid;
    logic [OUT_W-1:0] latency_ns;
    logic             submit_dropped;
  } vftm_out_t;

endpackage

### rtl/vftm_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing

module vftm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/vftm_stamp_mul.sv
// bit-serial conversion of a seconds/microseconds stamp into nanoseconds
// depends on vftm_pkg; one seconds bit per cycle, shift-and-add

module vftm_stamp_mul
  import vftm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SEC_W-1:0]   sec,
  input  logic [USEC_W-1:0]  usec,
  output logic               done,
  output logic [STAMP_W-1:0] stamp
);

  localparam int STEP_W = $clog2(SEC_W);

  logic [STAMP_W-1:0] acc_r, acc_nxt;
  logic [STAMP_W-1:0] mcand_r, mcand_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STAMP_W-1:0] usec_ext;
  logic [STAMP_W-1:0] usec_ns;

  // usec * 1000 as usec * (1024 - 16 - 8)
  assign usec_ext = STAMP_W'(usec);
  assign usec_ns  = (usec_ext << 10) - (usec_ext << 4) - (usec_ext << 3);

  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    sec_nxt   = sec_r;
    step_nxt  = step_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      acc_nxt   = usec_ns;
      mcand_nxt = NS_PER_SEC;
      sec_nxt   = sec;
      step_nxt  = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (sec_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r << 1;
      sec_nxt   = sec_r >> 1;
      step_nxt  = step_r + 1'b1;
      if (step_r == STEP_W'(SEC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    sec_r   <= sec_nxt;
  end

  assign done  = done_r;
  assign stamp = acc_r;

endmodule

### rtl/vftm_div.sv
// radix-2 restoring divider: 64-bit time delta over 32-bit counter delta
// depends on vftm_pkg; quotient saturates at 32 bits, one bit per cycle

module vftm_div
  import vftm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [STAMP_W-1:0] dividend,
  input  logic [OUT_W-1:0]   divisor,
  output logic               done,
  output logic [OUT_W-1:0]   quot
);

  localparam int STEP_W = $clog2(OUT_W);

  logic [OUT_W-1:0]  rem_r, rem_nxt;
  logic [OUT_W-1:0]  q_r, q_nxt;
  logic [OUT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [OUT_W:0]    trial;
  logic [OUT_W:0]    diff;
  logic              ge;
  logic [OUT_W-1:0]  hi;

  assign hi    = dividend[STAMP_W-1 -: OUT_W];
  assign trial = {rem_r, q_r[OUT_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvs_nxt  = divisor;
      step_nxt = '0;
      if (hi >= divisor) begin
        // quotient would not fit in 32 bits
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = hi;
        q_nxt    = dividend[OUT_W-1:0];
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // remainder stays below the divisor, so the difference fits
      rem_nxt  = ge ? diff[OUT_W-1:0] : trial[OUT_W-1:0];
      q_nxt    = {q_r[OUT_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(OUT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### rtl/vsync_flip_timing_monitor_core.sv
// top level of the vsync flip timing monitor: control sequencer and state
// depends on vftm_pkg, vftm_ram, vftm_stamp_mul and vftm_div

// The monitor takes one item at a time and returns exactly one result item
// for each. Submit, discard and reset items go from idle straight to the
// output state. A flip first turns its seconds/microseconds stamp into
// nanoseconds in a bit-serial shift-and-add unit (one seconds bit per cycle),
// then pairs it with the oldest pending submit and updates the period state.
// When a period is measured and the counter has advanced, a restoring divider
// (one quotient bit per cycle) divides the time delta by the counter delta.
// Results sit in an output register, so the next item is accepted while a
// result waits to be taken. Pending submit stamps live in a ram of
// PENDING_DEPTH entries; a submit with a full queue is dropped and flagged.
// Configuration (expected period, capture enable) is to be written by the
// user only while the block is idle; the block itself does not enforce it.
// Clearing capture empties the pending queue.

module vsync_flip_timing_monitor_core
  import vftm_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vftm_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vftm_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OUT_W-1:0]     cfg_wdata
);

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int FW = $clog2(PENDING_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_LAT  = 6'b000100,
    S_EVAL = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [OUT_W-1:0]   exp_r, exp_nxt;
  logic               cap_r, cap_nxt;
  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic [CNT_W-1:0]   last_cnt_r, last_cnt_nxt;
  logic               last_valid_r, last_valid_nxt;
  logic [OUT_W-1:0]   period_r, period_nxt;
  logic [OUT_W-1:0]   skipped_r, skipped_nxt;
  logic [OUT_W-1:0]   drop_r, drop_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]   cnt_in_r, cnt_in_nxt;
  logic               lat_valid_r, lat_valid_nxt;
  logic [OUT_W-1:0]   lat_r, lat_nxt;
  logic               sub_drop_r, sub_drop_nxt;
  logic               out_valid_r, out_valid_nxt;
  vftm_out_t          out_data_r, out_data_nxt;

  logic               mul_start, mul_done;
  logic [STAMP_W-1:0] stamp;
  logic               div_start, div_done;
  logic [OUT_W-1:0]   quot;
  logic               ram_we, ram_re;
  logic [NOW_W-1:0]   sub_stamp;

  // datapath terms of a flip
  logic [STAMP_W-1:0] dt;
  logic [CNT_W-1:0]   dc;
  logic               meas;
  logic [STAMP_W-1:0] lat_diff;
  logic               lat_ok;
  logic [OUT_W:0]     drop_sum;
  logic               q_empty, q_full;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    ptr_inc = (ptr == AW'(PENDING_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  vftm_stamp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .sec   (in_data.flip_seconds),
    .usec  (in_data.flip_micros),
    .done  (mul_done),
    .stamp (stamp)
  );

  vftm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dt),
    .divisor  (dc),
    .done     (div_done),
    .quot     (quot)
  );

  vftm_ram #(
    .WIDTH (NOW_W),
    .DEPTH (PENDING_DEPTH),
    .AW    (AW)
  ) u_pending (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_data.now_ns),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (sub_stamp)
  );

  assign q_empty = (fill_r == '0);
  assign q_full  = (fill_r == FW'(PENDING_DEPTH));

  // measurement needs an earlier nonzero stamp that is older than this one
  assign meas = last_valid_r && (last_stamp_r != '0) && (stamp > last_stamp_r);
  assign dt   = stamp - last_stamp_r;
  assign dc   = cnt_in_r - last_cnt_r;

  // submit-to-flip latency only when the flip stamp is later than the submit
  assign lat_diff = stamp - {1'b0, sub_stamp};
  assign lat_ok   = (stamp != '0) && (stamp > {1'b0, sub_stamp});

  assign drop_sum = {1'b0, drop_r} + {1'b0, skipped_r};

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    exp_nxt        = exp_r;
    cap_nxt        = cap_r;
    last_stamp_nxt = last_stamp_r;
    last_cnt_nxt   = last_cnt_r;
    last_valid_nxt = last_valid_r;
    period_nxt     = period_r;
    skipped_nxt    = skipped_r;
    drop_nxt       = drop_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    cnt_in_nxt     = cnt_in_r;
    lat_valid_nxt  = lat_valid_r;
    lat_nxt        = lat_r;
    sub_drop_nxt   = sub_drop_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // the user must write registers only while idle; the block itself does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED: begin
          exp_nxt = cfg_wdata;
        end
        CFG_CAPTURE: begin
          cap_nxt = cfg_wdata[0];
          if (!cfg_wdata[0]) begin
            head_nxt = '0;
            tail_nxt = '0;
            fill_nxt = '0;
          end
        end
        default: begin
          exp_nxt = exp_r;
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lat_valid_nxt = 1'b0;
          lat_nxt       = '0;
          sub_drop_nxt  = 1'b0;
          state_nxt     = S_OUT;
          case (in_data.kind)
            KIND_FLIP: begin
              // start the stamp conversion and fetch the oldest submit
              mul_start  = 1'b1;
              ram_re     = 1'b1;
              cnt_in_nxt = in_data.flip_counter;
              state_nxt  = S_MUL;
            end
            KIND_SUBMIT: begin
              if (cap_r) begin
                if (q_full) begin
                  sub_drop_nxt = 1'b1;
                end else begin
                  ram_we   = 1'b1;
                  tail_nxt = ptr_inc(tail_r);
                  fill_nxt = fill_r + 1'b1;
                end
              end
            end
            KIND_DISCARD: begin
              if (!q_empty) begin
                head_nxt = ptr_inc(head_r);
                fill_nxt = fill_r - 1'b1;
              end
            end
            KIND_RESET: begin
              last_stamp_nxt = '0;
              last_cnt_nxt   = '0;
              last_valid_nxt = 1'b0;
              period_nxt     = '0;
              skipped_nxt    = '0;
              drop_nxt       = '0;
              head_nxt       = '0;
              tail_nxt       = '0;
              fill_nxt       = '0;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_LAT;
        end
      end

      S_LAT: begin
        // pop the oldest pending submit and pair it with this flip
        if (cap_r && !q_empty) begin
          head_nxt = ptr_inc(head_r);
          fill_nxt = fill_r - 1'b1;
          if (lat_ok) begin
            lat_valid_nxt = 1'b1;
            lat_nxt       = (lat_diff[STAMP_W-1:OUT_W] != '0) ? '1 : lat_diff[OUT_W-1:0];
          end
        end
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        state_nxt = S_OUT;
        if (meas) begin
          if (cnt_in_r > last_cnt_r) begin
            div_start   = 1'b1;
            skipped_nxt = dc - 1'b1;
            state_nxt   = S_DIV;
          end else if (cnt_in_r == last_cnt_r) begin
            skipped_nxt = '0;
          end else begin
            // counter went backwards
            period_nxt  = exp_r;
            skipped_nxt = '0;
          end
        end else if (exp_r != '0) begin
          period_nxt  = exp_r;
          skipped_nxt = '0;
        end
        last_stamp_nxt = stamp;
        last_cnt_nxt   = cnt_in_r;
        last_valid_nxt = 1'b1;
      end

      S_DIV: begin
        if (div_done) begin
          period_nxt = quot;
          // only multi-vsync skips count as drops
          if (skipped_r[OUT_W-1:1] != '0) begin
            drop_nxt = drop_sum[OUT_W] ? '1 : drop_sum[OUT_W-1:0];
          end
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.period_ns      = period_r;
          out_data_nxt.skipped_count  = skipped_r;
          out_data_nxt.drop_total     = drop_r;
          out_data_nxt.latency_valid  = lat_valid_r;
          out_data_nxt.latency_ns     = lat_r;
          out_data_nxt.submit_dropped = sub_drop_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      exp_r        <= EXPECTED_RST;
      cap_r        <= 1'b0;
      last_stamp_r <= '0;
      last_cnt_r   <= '0;
      last_valid_r <= 1'b0;
      period_r     <= '0;
      skipped_r    <= '0;
      drop_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      exp_r        <= exp_nxt;
      cap_r        <= cap_nxt;
      last_stamp_r <= last_stamp_nxt;
      last_cnt_r   <= last_cnt_nxt;
      last_valid_r <= last_valid_nxt;
      period_r     <= period_nxt;
      skipped_r    <= skipped_nxt;
      drop_r       <= drop_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cnt_in_r    <= cnt_in_nxt;
    lat_valid_r <= lat_valid_nxt;
    lat_r       <= lat_nxt;
    sub_drop_r  <= sub_drop_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/vftm_checker.sv
// port-level checks of the vsync flip timing monitor, bound to the top level
// depends on vftm_pkg and vsync_flip_timing_monitor_core

module vftm_checker
  import vftm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input vftm_out_t out_data
);

  // one item in flight: an accepted item closes the input for the next cycle
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accepted item");

  // a reported latency is strictly positive
  a_lat_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.latency_valid |-> out_data.latency_ns != '0)
    else $error("latency flagged valid but zero");

  a_lat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.latency_valid |-> out_data.latency_ns == '0)
    else $error("latency nonzero without latency_valid");

  // a flip and a submit never share a result
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.latency_valid && out_data.submit_dropped))
    else $error("latency and submit drop in one item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind vsync_flip_timing_monitor_core vftm_checker u_vftm_checker (.*);
